FILE: rtl/core/m4au_pkg.sv
`timescale 1ns / 1ps
package m4au_pkg;

  localparam int DIM = 4;
  localparam int CELLS = DIM * DIM;
  localparam int IDXW = $clog2(CELLS);
  localparam int KW = $clog2(DIM);

  typedef enum logic [2:0] {
    OP_MUL   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_SCALE = 3'd3,
    OP_TRANS = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_EMIT
  } state_t;

  // control handed from the sequencer to each cell
  typedef struct packed {
    logic          clear;
    logic          step;
    logic          done;
    logic [KW-1:0] k;
    logic [2:0]    op;
  } cell_ctl_t;

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sh0_0000_7FFF_FFFF;
    lo = -50'sh0_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: rtl/core/m4au_cell.sv
`timescale 1ns / 1ps
// one result element: DIM-step multiply-accumulate, or add, subtract,
// scale or transpose; result shifts along the chain toward the output
module m4au_cell (
  input  logic                     clk,
  input  m4au_pkg::cell_ctl_t      ctl,
  input  logic                     shift,
  input  logic signed [31:0]       a,
  input  logic signed [31:0]       b,
  input  logic signed [31:0]       s,
  input  logic [31:0]              chain_in,
  output logic [31:0]              chain_out
);

  logic signed [63:0] prod;
  logic signed [49:0] acc;
  logic signed [49:0] acc_next;
  logic               phase;
  logic [31:0]        res;

  assign chain_out = res;

  // product registered before it is accumulated
  always_ff @(posedge clk) begin
    prod <= (ctl.op == m4au_pkg::OP_SCALE) ? a * s : a * b;
  end

  always_comb begin
    acc_next = acc + 50'(prod >>> 16);
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
      phase <= 1'b0;
    end else if (ctl.step) begin
      phase <= 1'b1;
      if (phase) begin
        acc <= acc_next;
      end
    end
    if (shift) begin
      res <= chain_in;
    end else if (ctl.step && ctl.done && phase) begin
      unique case (ctl.op)
        m4au_pkg::OP_MUL:   res <= m4au_pkg::sat32(acc_next);
        m4au_pkg::OP_SCALE: res <= m4au_pkg::sat32(50'(prod >>> 16));
        m4au_pkg::OP_ADD:   res <= m4au_pkg::sat32(50'(a) + 50'(b));
        m4au_pkg::OP_SUB:   res <= m4au_pkg::sat32(50'(a) - 50'(b));
        m4au_pkg::OP_TRANS: res <= a;
        default:            res <= '0;
      endcase
    end
  end

endmodule

FILE: rtl/core/m4au_seq.sv
`timescale 1ns / 1ps
module m4au_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [2:0]                op_in,
  output m4au_pkg::cell_ctl_t       ctl,
  output logic                      shift,
  output logic                      busy,
  output logic                      strobe,
  output logic [m4au_pkg::IDXW-1:0] out_idx,
  output logic                      out_last
);

  m4au_pkg::state_t state, state_next;
  logic [m4au_pkg::KW:0]   cnt;
  logic [m4au_pkg::IDXW:0] ocnt;
  logic [2:0]              op;

  always_comb begin
    state_next = state;
    unique case (state)
      m4au_pkg::ST_LOAD: if (go) state_next = m4au_pkg::ST_CALC;
      m4au_pkg::ST_CALC: if (cnt == (m4au_pkg::KW+1)'(m4au_pkg::DIM)) begin
        state_next = m4au_pkg::ST_EMIT;
      end
      m4au_pkg::ST_EMIT: if (ocnt == (m4au_pkg::IDXW+1)'(m4au_pkg::CELLS - 1)) begin
        state_next = m4au_pkg::ST_LOAD;
      end
      default: state_next = m4au_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    busy = (state != m4au_pkg::ST_LOAD);
    strobe = (state == m4au_pkg::ST_EMIT);
    shift = strobe;
    ctl.clear = (state == m4au_pkg::ST_LOAD);
    ctl.step = (state == m4au_pkg::ST_CALC);
    // operands for step k are addressed at count k; the product lands in
    // the next cycle, so the extra final count only adds the last product
    ctl.k = m4au_pkg::KW'(cnt);
    ctl.done = (cnt == (m4au_pkg::KW+1)'(m4au_pkg::DIM));
    ctl.op = op;
    out_idx = ocnt[m4au_pkg::IDXW-1:0];
    out_last = (ocnt == (m4au_pkg::IDXW+1)'(m4au_pkg::CELLS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m4au_pkg::ST_LOAD;
      cnt <= '0;
      ocnt <= '0;
    end else begin
      state <= state_next;
      if (state == m4au_pkg::ST_CALC) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (state == m4au_pkg::ST_EMIT) begin
        ocnt <= ocnt + 1'b1;
      end else begin
        ocnt <= '0;
      end
    end
    if (go && state == m4au_pkg::ST_LOAD) begin
      op <= op_in;
    end
  end

endmodule

FILE: rtl/core/matrix4_arithmetic_unit.sv
`timescale 1ns / 1ps
// channel   | ports                                               | handshake
// load in   | operation element_index left_element right_element  | start, busy
//           | scalar_value last_element                           |
// result    | result_element result_index result_last             | strobe
// a load item is taken while start is high and busy is low; the item marked
// last raises busy for the calculation steps (one step per cycle in every
// cell), then while results shift out of the cell chain, one per cycle.
// reset returns to loading; store contents are kept but undefined at start.
// the receiver cannot stall: each result shows for exactly one cycle.
module matrix4_arithmetic_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [3:0]  element_index,
  input  logic [31:0] left_element,
  input  logic [31:0] right_element,
  input  logic [31:0] scalar_value,
  input  logic        last_element,
  output logic        strobe,
  output logic [31:0] result_element,
  output logic [3:0]  result_index,
  output logic        result_last
);

  localparam int N = m4au_pkg::CELLS;
  localparam int D = m4au_pkg::DIM;

  logic [31:0] left_store [N];
  logic [31:0] right_store [N];
  logic [31:0] scalar;
  logic [31:0] chain [N+1];
  logic        go;
  logic        shift;
  m4au_pkg::cell_ctl_t ctl;

  assign go = start && !busy && last_element;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      if (32'(element_index) < N) begin
        left_store[element_index[m4au_pkg::IDXW-1:0]] <= left_element;
        right_store[element_index[m4au_pkg::IDXW-1:0]] <= right_element;
      end
      if (last_element) begin
        scalar <= scalar_value;
      end
    end
  end

  m4au_seq u_seq (
    .clk(clk), .rst(rst), .go(go), .op_in(operation), .ctl(ctl), .shift(shift),
    .busy(busy), .strobe(strobe), .out_idx(result_index), .out_last(result_last)
  );

  assign chain[N] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int R = g / D;
    localparam int C = g % D;
    logic [31:0] a_sel, b_sel;
    always_comb begin
      unique case (ctl.op)
        m4au_pkg::OP_MUL: begin
          a_sel = left_store[R * D + int'(ctl.k)];
          b_sel = right_store[int'(ctl.k) * D + C];
        end
        m4au_pkg::OP_TRANS: begin
          a_sel = left_store[C * D + R];
          b_sel = right_store[g];
        end
        default: begin
          a_sel = left_store[g];
          b_sel = right_store[g];
        end
      endcase
    end
    m4au_cell u_cell (
      .clk(clk), .ctl(ctl), .shift(shift), .a(a_sel), .b(b_sel), .s(scalar),
      .chain_in(chain[g+1]), .chain_out(chain[g])
    );
  end

  assign result_element = chain[0];

endmodule

FILE: rtl/core/m4au_checker.sv
`timescale 1ns / 1ps
module m4au_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       last_element,
  input logic       strobe,
  input logic [3:0] result_index,
  input logic       result_last
);

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("strobe without busy");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    strobe && result_last |-> result_index == 4'd15) else $error("last index");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    strobe && !result_last |=> strobe && result_index == $past(result_index) + 4'd1)
    else $error("index sequence");
  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_element |=> busy) else $error("no busy after start");
  a_first: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> result_index == 4'd0) else $error("first index");

endmodule

bind matrix4_arithmetic_unit m4au_checker u_m4au_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .last_element(last_element),
  .strobe(strobe), .result_index(result_index), .result_last(result_last)
);
